[rtl/ppmc_pkg.sv]
// shared constants and control types of the page protection map checker
package ppmc_pkg;

    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_COUNT = 524288;
    localparam int PAGE_W     = $clog2(PAGE_COUNT);
    localparam int PNUM_W     = ADDR_W - PAGE_SHIFT;
    localparam int STOP_W     = ADDR_W + 2 - PAGE_SHIFT;
    localparam int CMP_W      = ADDR_W + 1;
    localparam int CNT_W      = PAGE_W + 1;

    localparam logic KIND_SET   = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic fill_one;
        logic rd_first;
        logic rd_last;
        logic grab;
        logic result;
    } ppmc_cmd_t;

    typedef struct packed {
        logic more;
        logic is_check;
    } ppmc_stat_t;

endpackage

[rtl/ppmc_ram.sv]
// generic single-write, single-read ram with registered read data
module ppmc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ppmc_dp.sv]
// datapath: item registers, page walk counter, flag memory and result register
module ppmc_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ppmc_pkg::ppmc_cmd_t       cmd,
    output ppmc_pkg::ppmc_stat_t      stat,
    input  logic                      kind,
    input  logic [ppmc_pkg::ADDR_W-1:0] address,
    input  logic [ppmc_pkg::ADDR_W-1:0] length,
    input  logic                      flag_value,
    output logic                      violation
);

    logic                            kind_reg;
    logic [ppmc_pkg::ADDR_W-1:0]     addr_reg;
    logic [ppmc_pkg::ADDR_W-1:0]     len_reg;
    logic                            val_reg;
    logic [ppmc_pkg::PNUM_W-1:0]     last_pn_reg;
    logic [ppmc_pkg::CNT_W-1:0]      page_reg;
    logic [ppmc_pkg::CNT_W-1:0]      page_next;
    logic [ppmc_pkg::CNT_W-1:0]      stop_reg;
    logic [ppmc_pkg::CNT_W-1:0]      stop_next;
    logic                            hit_reg;
    logic                            rd_oob_reg;
    logic                            violation_reg;

    logic [ppmc_pkg::CMP_W-1:0]      end_sum;
    logic [ppmc_pkg::STOP_W-1:0]     stop_raw;
    logic [ppmc_pkg::PNUM_W-1:0]     first_pn;
    logic [ppmc_pkg::ADDR_W-1:0]     last_byte;
    logic                            start_oob;
    logic [ppmc_pkg::PNUM_W-1:0]     rd_pn;
    logic                            rd_oob;
    logic [0:0]                      wdata;
    logic [0:0]                      rdata;

    assign first_pn  = addr_reg[ppmc_pkg::ADDR_W-1:ppmc_pkg::PAGE_SHIFT];
    assign end_sum   = {1'b0, addr_reg} + {1'b0, len_reg};
    assign stop_raw  = ppmc_pkg::STOP_W'(end_sum[ppmc_pkg::CMP_W-1:ppmc_pkg::PAGE_SHIFT])
                     + ppmc_pkg::STOP_W'(|end_sum[ppmc_pkg::PAGE_SHIFT-1:0]);
    assign start_oob = ppmc_pkg::CMP_W'(first_pn) >= ppmc_pkg::CMP_W'(ppmc_pkg::PAGE_COUNT);
    assign last_byte = addr_reg + len_reg - ppmc_pkg::ADDR_W'(1);

    // page range of a set beat, clipped at the boundary
    always_comb
    begin
        page_next = page_reg;
        stop_next = stop_reg;
        if (cmd.prep)
        begin
            if (start_oob)
            begin
                page_next = '0;
                stop_next = '0;
            end
            else
            begin
                page_next = ppmc_pkg::CNT_W'(first_pn);
                if (ppmc_pkg::CMP_W'(stop_raw) > ppmc_pkg::CMP_W'(ppmc_pkg::PAGE_COUNT))
                begin
                    stop_next = ppmc_pkg::CNT_W'(ppmc_pkg::PAGE_COUNT);
                end
                else
                begin
                    stop_next = ppmc_pkg::CNT_W'(stop_raw);
                end
            end
        end
        else if (cmd.step)
        begin
            page_next = page_reg + ppmc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg <= '0;
            stop_reg <= ppmc_pkg::CNT_W'(ppmc_pkg::PAGE_COUNT);
        end
        else
        begin
            page_reg <= page_next;
            stop_reg <= stop_next;
        end
    end

    assign rd_pn  = cmd.rd_last ? last_pn_reg : first_pn;
    assign rd_oob = ppmc_pkg::CMP_W'(rd_pn) >= ppmc_pkg::CMP_W'(ppmc_pkg::PAGE_COUNT);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            addr_reg <= address;
            len_reg  <= length;
            val_reg  <= flag_value;
        end
        if (cmd.prep)
        begin
            last_pn_reg <= last_byte[ppmc_pkg::ADDR_W-1:ppmc_pkg::PAGE_SHIFT];
            hit_reg     <= 1'b0;
        end
        else if (cmd.grab)
        begin
            hit_reg <= hit_reg | rd_oob_reg | rdata[0];
        end
        if (cmd.rd_first || cmd.rd_last)
        begin
            rd_oob_reg <= rd_oob;
        end
        if (cmd.result)
        begin
            violation_reg <= (kind_reg == ppmc_pkg::KIND_CHECK) ? hit_reg : 1'b0;
        end
    end

    assign wdata = cmd.fill_one ? 1'b1 : val_reg;

    ppmc_ram #(
        .WIDTH (1),
        .DEPTH (ppmc_pkg::PAGE_COUNT)
    ) u_flags (
        .clk   (clk),
        .we    (cmd.step),
        .waddr (page_reg[ppmc_pkg::PAGE_W-1:0]),
        .wdata (wdata),
        .raddr (rd_pn[ppmc_pkg::PAGE_W-1:0]),
        .rdata (rdata)
    );

    assign stat.more     = page_reg < stop_reg;
    assign stat.is_check = kind_reg == ppmc_pkg::KIND_CHECK;
    assign violation     = violation_reg;

endmodule

[rtl/ppmc_ctrl.sv]
// controller: clearing pass, page walk sequencing, flag reads and result handshake
module ppmc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    output logic                 result_valid,
    input  logic                 result_ready,
    output ppmc_pkg::ppmc_cmd_t  cmd,
    input  ppmc_pkg::ppmc_stat_t stat
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_SET   = 3'd3;
    localparam logic [2:0] S_RD1   = 3'd4;
    localparam logic [2:0] S_RD2   = 3'd5;
    localparam logic [2:0] S_GRAB  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       result_valid_reg;
    logic       result_valid_next;

    always_comb
    begin
        state_next        = state_reg;
        cmd               = '0;
        item_ready        = 1'b0;
        result_valid_next = result_valid_reg && !result_ready;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.more)
                begin
                    cmd.step     = 1'b1;
                    cmd.fill_one = 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = stat.is_check ? S_RD1 : S_SET;
            end
            S_SET:
            begin
                if (stat.more)
                begin
                    cmd.step = 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RD1:
            begin
                cmd.rd_first = 1'b1;
                state_next   = S_RD2;
            end
            S_RD2:
            begin
                cmd.rd_last = 1'b1;
                cmd.grab    = 1'b1;
                state_next  = S_GRAB;
            end
            S_GRAB:
            begin
                cmd.grab   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    cmd.result        = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

endmodule

[rtl/page_protection_map_checker.sv]
// top level of the page protection map checker
// After reset the block walks the whole flag memory once, one page per cycle, to mark
// every page protected: item_ready stays low until that pass is over. After that one
// item is worked at a time through a flag memory with one write port and one read
// port. A check beat reads the flag of the first-byte page and then of the last-byte
// page through the one read port. It keeps item_ready low after acceptance through the
// PREP, RD1, RD2, GRAB and DONE states. A set beat writes one page per cycle. It keeps
// item_ready low through PREP, through SET for each page of its clipped range and for
// the exit, and through DONE. The result sits in an output register, so the next item
// is taken while a result still waits for result_ready. The result of that next item
// is then held back, and item_ready with it, until the waiting result is accepted.
module page_protection_map_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic                        kind,
    input  logic [ppmc_pkg::ADDR_W-1:0] address,
    input  logic [ppmc_pkg::ADDR_W-1:0] length,
    input  logic                        flag_value,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic                        violation
);

    ppmc_pkg::ppmc_cmd_t  cmd;
    ppmc_pkg::ppmc_stat_t stat;

    ppmc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .stat         (stat)
    );

    ppmc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .kind       (kind),
        .address    (address),
        .length     (length),
        .flag_value (flag_value),
        .violation  (violation)
    );

endmodule
